/* rtl/core/lsa_pkg.sv */
`timescale 1ns / 1ps

package lsa_pkg;

	localparam int SLOT_COUNT = 64;
	localparam int REQ_COUNT  = 256;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int REQ_W      = $clog2(REQ_COUNT);
	localparam int CNT_W      = REQ_W + 1;
	localparam int CFG_W      = 7;
	localparam int AMT_W      = 16;
	localparam int PROD_W     = 2 * AMT_W;
	localparam int TOTAL_W    = 40;
	localparam int OP_W       = 3;
	localparam int EV_W       = 3;
	localparam int ID_W       = 8;
	localparam int IDX_W      = 6;

	localparam logic [OP_W-1:0] OP_LOAD_RATE   = 3'd0;
	localparam logic [OP_W-1:0] OP_LOAD_WEIGHT = 3'd1;
	localparam logic [OP_W-1:0] OP_ARRIVE      = 3'd2;
	localparam logic [OP_W-1:0] OP_DEPART      = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR       = 3'd4;

	localparam logic [EV_W-1:0] EV_LOADED   = 3'd0;
	localparam logic [EV_W-1:0] EV_GRANTED  = 3'd1;
	localparam logic [EV_W-1:0] EV_QUEUED   = 3'd2;
	localparam logic [EV_W-1:0] EV_RELEASED = 3'd3;
	localparam logic [EV_W-1:0] EV_CLEARED  = 3'd4;
	localparam logic [EV_W-1:0] EV_ERROR    = 3'd5;

endpackage

/* rtl/core/lsa_ram.sv */
`timescale 1ns / 1ps

module lsa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/lsa_prio.sv */
`timescale 1ns / 1ps

// Lowest set bit of the free map below the slot limit.
module lsa_prio (
	input  logic [lsa_pkg::SLOT_COUNT-1:0] map,
	input  logic [lsa_pkg::CFG_W-1:0]      lim,
	output logic                           found,
	output logic [lsa_pkg::SLOT_W-1:0]     idx
);

	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int i = lsa_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
			if (map[i] && (i < int'(lim))) begin
				found = 1'b1;
				idx   = lsa_pkg::SLOT_W'(i);
			end
		end
	end

endmodule

/* rtl/core/lowest_slot_allocator_with_wait_queue_core.sv */
`timescale 1ns / 1ps

// Channel   Dir  Handshake               Contents
// s_axis    in   tvalid/tready           one command item (op in tuser)
// m_axis    out  tvalid/tready, tlast    one event item (event in tuser)
// cfg       in   cfg_we                  slots_in_use
//
// One item is processed at a time. Loads, queueing, errors and clear go
// straight to the output handshake; a grant takes a table read, multiply
// and accumulate; a departure with regrant adds release and regrant steps,
// as the held-slot, queue and table memories have registered reads.
// Reset frees all slots, drops all holds, empties the queue and zeroes the
// total; table memories are not cleared. A stalled m_axis holds the block.
module lowest_slot_allocator_with_wait_queue_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [31:0]                   s_axis_tdata,  // requester, slot_index, amount
	input  logic [lsa_pkg::OP_W-1:0]      s_axis_tuser,  // op
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [55:0]                   m_axis_tdata,  // who, slot_number, running_total
	output logic [lsa_pkg::EV_W-1:0]      m_axis_tuser,  // event_res
	output logic                          m_axis_tlast,
	input  logic                          cfg_we,
	input  logic [lsa_pkg::CFG_W-1:0]     cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_REL, ST_REGRANT, ST_MUL, ST_ADD, ST_OUT
	} state_t;

	state_t state_q, nxt_q;

	logic [lsa_pkg::CFG_W-1:0]      cfg_q;
	logic [lsa_pkg::SLOT_COUNT-1:0] free_q;
	logic [lsa_pkg::REQ_COUNT-1:0]  holds_q;
	logic [lsa_pkg::REQ_W-1:0]      head_q, tail_q;
	logic [lsa_pkg::CNT_W-1:0]      cnt_q;
	logic [lsa_pkg::TOTAL_W-1:0]    total_q;

	logic [lsa_pkg::ID_W-1:0]       who_q, gwho_q;
	logic [lsa_pkg::SLOT_W-1:0]     slot_q;
	logic [lsa_pkg::PROD_W-1:0]     prod_s2;

	logic                           out_valid_q, out_last_q;
	logic [lsa_pkg::EV_W-1:0]       out_ev_q;
	logic [lsa_pkg::ID_W-1:0]       out_who_q;
	logic [lsa_pkg::IDX_W-1:0]      out_slot_q;
	logic [lsa_pkg::TOTAL_W-1:0]    out_total_q;

	// item fields
	logic                           acc;
	logic [lsa_pkg::OP_W-1:0]       in_op;
	logic [lsa_pkg::ID_W-1:0]       in_req;
	logic [lsa_pkg::IDX_W-1:0]      in_slot;
	logic [lsa_pkg::AMT_W-1:0]      in_amt;

	assign in_op   = s_axis_tuser;
	assign in_req  = s_axis_tdata[7:0];
	assign in_slot = s_axis_tdata[13:8];
	assign in_amt  = s_axis_tdata[29:14];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign acc           = s_axis_tvalid && s_axis_tready;

	// clamp the slot limit to 1..SLOT_COUNT
	logic [lsa_pkg::CFG_W-1:0] lim;
	always_comb begin
		if (cfg_q == '0) begin
			lim = lsa_pkg::CFG_W'(1);
		end else if (cfg_q > lsa_pkg::CFG_W'(lsa_pkg::SLOT_COUNT)) begin
			lim = lsa_pkg::CFG_W'(lsa_pkg::SLOT_COUNT);
		end else begin
			lim = cfg_q;
		end
	end

	// memories
	logic [lsa_pkg::AMT_W-1:0]  rate_rd, weight_rd;
	logic [lsa_pkg::SLOT_W-1:0] held_rd;
	logic [lsa_pkg::ID_W-1:0]   fifo_rd;

	logic                       found_a, found_b;
	logic [lsa_pkg::SLOT_W-1:0] idx_a, idx_b;
	logic [lsa_pkg::SLOT_COUNT-1:0] map_b;

	logic                       rate_we, weight_we, held_we, fifo_we;
	logic [lsa_pkg::REQ_W-1:0]  weight_raddr, held_waddr;

	lsa_prio u_prio_a (.map(free_q), .lim(lim), .found(found_a), .idx(idx_a));

	// free map as it stands once the departing slot is returned
	always_comb begin
		map_b          = free_q;
		map_b[held_rd] = 1'b1;
	end

	lsa_prio u_prio_b (.map(map_b), .lim(lim), .found(found_b), .idx(idx_b));

	assign rate_we      = acc && (in_op == lsa_pkg::OP_LOAD_RATE);
	assign weight_we    = acc && (in_op == lsa_pkg::OP_LOAD_WEIGHT);
	assign held_we      = (acc && (in_op == lsa_pkg::OP_ARRIVE) && found_a)
		|| (state_q == ST_REGRANT);
	assign fifo_we      = acc && (in_op == lsa_pkg::OP_ARRIVE) && !found_a
		&& (cnt_q < lsa_pkg::CNT_W'(lsa_pkg::REQ_COUNT));
	assign weight_raddr = (state_q == ST_IDLE) ? in_req : gwho_q;
	assign held_waddr   = (state_q == ST_REGRANT) ? gwho_q : in_req;

	lsa_ram #(.WIDTH(lsa_pkg::AMT_W), .DEPTH(lsa_pkg::SLOT_COUNT)) u_rate (
		.clk(clk), .we(rate_we), .waddr(in_slot), .wdata(in_amt),
		.raddr(idx_a), .rdata(rate_rd)
	);

	lsa_ram #(.WIDTH(lsa_pkg::AMT_W), .DEPTH(lsa_pkg::REQ_COUNT)) u_weight (
		.clk(clk), .we(weight_we), .waddr(in_req), .wdata(in_amt),
		.raddr(weight_raddr), .rdata(weight_rd)
	);

	lsa_ram #(.WIDTH(lsa_pkg::SLOT_W), .DEPTH(lsa_pkg::REQ_COUNT)) u_held (
		.clk(clk), .we(held_we), .waddr(held_waddr), .wdata(idx_a),
		.raddr(in_req), .rdata(held_rd)
	);

	lsa_ram #(.WIDTH(lsa_pkg::ID_W), .DEPTH(lsa_pkg::REQ_COUNT)) u_fifo (
		.clk(clk), .we(fifo_we), .waddr(tail_q), .wdata(in_req),
		.raddr(head_q), .rdata(fifo_rd)
	);

	// saturating accumulate
	logic [lsa_pkg::TOTAL_W:0]   sum_w;
	logic [lsa_pkg::TOTAL_W-1:0] sum_sat;
	assign sum_w   = {1'b0, total_q} + (lsa_pkg::TOTAL_W + 1)'(prod_s2);
	assign sum_sat = sum_w[lsa_pkg::TOTAL_W] ? '1 : sum_w[lsa_pkg::TOTAL_W-1:0];

	logic more;
	assign more = (cnt_q != '0) && found_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			nxt_q       <= ST_IDLE;
			cfg_q       <= lsa_pkg::CFG_W'(64);
			free_q      <= '1;
			holds_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						// default result shape; arms override
						out_who_q   <= in_req;
						out_slot_q  <= '0;
						out_last_q  <= 1'b1;
						out_total_q <= total_q;
						nxt_q       <= ST_IDLE;
						who_q       <= in_req;
						case (in_op)
							lsa_pkg::OP_LOAD_RATE: begin
								out_ev_q    <= lsa_pkg::EV_LOADED;
								out_who_q   <= '0;
								out_valid_q <= 1'b1;
								state_q     <= ST_OUT;
							end
							lsa_pkg::OP_LOAD_WEIGHT: begin
								out_ev_q    <= lsa_pkg::EV_LOADED;
								out_valid_q <= 1'b1;
								state_q     <= ST_OUT;
							end
							lsa_pkg::OP_ARRIVE: begin
								if (found_a) begin
									free_q[idx_a]   <= 1'b0;
									holds_q[in_req] <= 1'b1;
									slot_q          <= idx_a;
									state_q         <= ST_MUL;
								end else begin
									if (fifo_we) begin
										tail_q   <= tail_q + 1'b1;
										cnt_q    <= cnt_q + 1'b1;
										out_ev_q <= lsa_pkg::EV_QUEUED;
									end else begin
										out_ev_q <= lsa_pkg::EV_ERROR;
									end
									out_valid_q <= 1'b1;
									state_q     <= ST_OUT;
								end
							end
							lsa_pkg::OP_DEPART: begin
								if (holds_q[in_req]) begin
									state_q <= ST_REL;
								end else begin
									out_ev_q    <= lsa_pkg::EV_ERROR;
									out_valid_q <= 1'b1;
									state_q     <= ST_OUT;
								end
							end
							lsa_pkg::OP_CLEAR: begin
								free_q      <= '1;
								holds_q     <= '0;
								head_q      <= '0;
								tail_q      <= '0;
								cnt_q       <= '0;
								total_q     <= '0;
								out_ev_q    <= lsa_pkg::EV_CLEARED;
								out_who_q   <= '0;
								out_total_q <= '0;
								out_valid_q <= 1'b1;
								state_q     <= ST_OUT;
							end
							default: begin
							end
						endcase
					end
				end
				ST_REL: begin
					free_q[held_rd] <= 1'b1;
					holds_q[who_q]  <= 1'b0;
					gwho_q          <= fifo_rd;
					slot_q          <= idx_b;
					out_ev_q        <= lsa_pkg::EV_RELEASED;
					out_who_q       <= who_q;
					out_slot_q      <= held_rd;
					out_last_q      <= !more;
					out_total_q     <= total_q;
					out_valid_q     <= 1'b1;
					nxt_q           <= more ? ST_REGRANT : ST_IDLE;
					state_q         <= ST_OUT;
				end
				ST_REGRANT: begin
					// slot_q holds the lowest free slot once the departing one returned
					free_q[slot_q]  <= 1'b0;
					holds_q[gwho_q] <= 1'b1;
					head_q          <= head_q + 1'b1;
					cnt_q           <= cnt_q - 1'b1;
					who_q           <= gwho_q;
					state_q         <= ST_MUL;
				end
				ST_MUL: begin
					prod_s2 <= weight_rd * rate_rd;
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					total_q     <= sum_sat;
					out_ev_q    <= lsa_pkg::EV_GRANTED;
					out_who_q   <= who_q;
					out_slot_q  <= slot_q;
					out_last_q  <= 1'b1;
					out_total_q <= sum_sat;
					out_valid_q <= 1'b1;
					nxt_q       <= ST_IDLE;
					state_q     <= ST_OUT;
				end
				ST_OUT: begin
					// hold the event until taken
					if (m_axis_tready) begin
						out_valid_q <= 1'b0;
						state_q     <= nxt_q;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_ev_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {2'b00, out_total_q, out_slot_q, out_who_q};

`ifndef SYNTHESIS
	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |-> !m_axis_tvalid)
		else $error("item accepted while an event is pending");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= lsa_pkg::CNT_W'(lsa_pkg::REQ_COUNT))
		else $error("wait queue count overflow");

	a_grant_taken: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == lsa_pkg::EV_GRANTED) |-> !free_q[out_slot_q])
		else $error("granted slot still marked free");
`endif

endmodule

/* verif/lsa_checker.sv */
`timescale 1ns / 1ps

module lsa_checker
	import lsa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	input  logic              s_axis_tready,
	input  logic [31:0]       s_axis_tdata,
	input  logic [OP_W-1:0]   s_axis_tuser,
	input  logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	input  logic [55:0]       m_axis_tdata,
	input  logic [EV_W-1:0]   m_axis_tuser,
	input  logic              m_axis_tlast,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic [EV_W-1:0]    ev;
		logic [ID_W-1:0]    who;
		logic [IDX_W-1:0]   slot;
		logic [TOTAL_W-1:0] total;
		logic               last;
	} event_t;

	localparam logic [TOTAL_W-1:0] TOTAL_SAT = '1;

	event_t             event_q[$];
	logic [CFG_W-1:0]   slots_cfg;
	bit                 slot_free [SLOT_COUNT];
	logic [AMT_W-1:0]   slot_rate [SLOT_COUNT];
	logic [AMT_W-1:0]   req_weight [REQ_COUNT];
	logic [SLOT_W-1:0]  req_slot [REQ_COUNT];
	bit                 req_holds [REQ_COUNT];
	logic [ID_W-1:0]    wait_q [REQ_COUNT];
	logic [REQ_W-1:0]   wq_head, wq_tail;
	logic [CNT_W-1:0]   wq_count;
	logic [TOTAL_W-1:0] grant_total;

	function automatic int lowest_free();
		int lim;
		lim = (slots_cfg == 0) ? 1
			: (slots_cfg > SLOT_COUNT) ? SLOT_COUNT : int'(slots_cfg);
		for (int s = 0; s < lim; s++)
			if (slot_free[s]) return s;
		return -1;
	endfunction

	task automatic give_slot(input logic [ID_W-1:0] rid, input int s);
		logic [TOTAL_W:0] sum;
		sum = {1'b0, grant_total} + (req_weight[rid] * slot_rate[s]);
		slot_free[s] = 0;
		req_slot[rid] = s;
		req_holds[rid] = 1;
		grant_total = sum[TOTAL_W] ? TOTAL_SAT : sum[TOTAL_W-1:0];
	endtask

	task automatic push_event(input logic [EV_W-1:0] ev, input logic [ID_W-1:0] who,
			input logic [IDX_W-1:0] slot);
		event_q.push_back('{ev, who, slot, grant_total, 1'b0});
	endtask

	// Work out the events that one accepted command causes, in order.
	task automatic predict_events(input logic [OP_W-1:0] op, input logic [31:0] data);
		logic [ID_W-1:0]  rid;
		logic [IDX_W-1:0] sidx;
		logic [AMT_W-1:0] amt;
		logic [ID_W-1:0]  head;
		int               s, n0;
		rid  = data[7:0];
		sidx = data[13:8];
		amt  = data[29:14];
		n0   = event_q.size();
		case (op)
			OP_LOAD_RATE: begin
				slot_rate[sidx] = amt;
				push_event(EV_LOADED, '0, '0);
			end
			OP_LOAD_WEIGHT: begin
				req_weight[rid] = amt;
				push_event(EV_LOADED, rid, '0);
			end
			OP_ARRIVE: begin
				s = lowest_free();
				if (s >= 0) begin
					give_slot(rid, s);
					push_event(EV_GRANTED, rid, s);
				end else if (wq_count < REQ_COUNT) begin
					wait_q[wq_tail] = rid;
					wq_tail++;
					wq_count++;
					push_event(EV_QUEUED, rid, '0);
				end else begin
					push_event(EV_ERROR, rid, '0);
				end
			end
			OP_DEPART: begin
				if (!req_holds[rid]) begin
					push_event(EV_ERROR, rid, '0);
				end else begin
					slot_free[req_slot[rid]] = 1;
					req_holds[rid] = 0;
					push_event(EV_RELEASED, rid, req_slot[rid]);
					// Hand the freed capacity to the oldest waiter, if a usable slot exists.
					s = lowest_free();
					if (wq_count > 0 && s >= 0) begin
						head = wait_q[wq_head];
						wq_head++;
						wq_count--;
						give_slot(head, s);
						push_event(EV_GRANTED, head, s);
					end
				end
			end
			OP_CLEAR: begin
				foreach (slot_free[i]) slot_free[i] = 1;
				foreach (req_holds[i]) req_holds[i] = 0;
				wq_head = '0;
				wq_tail = '0;
				wq_count = '0;
				grant_total = '0;
				push_event(EV_CLEARED, '0, '0);
			end
			default: ;
		endcase
		if (event_q.size() > n0) event_q[event_q.size()-1].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		event_t got, want;
		if (!arst_n) begin
			event_q.delete();
			slots_cfg = CFG_W'(SLOT_COUNT);
			foreach (slot_free[i]) slot_free[i] = 1;
			foreach (req_holds[i]) req_holds[i] = 0;
			wq_head = '0;
			wq_tail = '0;
			wq_count = '0;
			grant_total = '0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) slots_cfg = cfg_wdata;
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[13:8],
					m_axis_tdata[53:14], m_axis_tlast};
				if (event_q.size() == 0) begin
					$display("%0t: unexpected event, actual %h", $realtime, got);
					fail_count <= fail_count + 1;
				end else begin
					want = event_q.pop_front();
					if (got !== want || m_axis_tdata[55:54] !== 2'b00) begin
						$display({"%0t: event mismatch, expected ev=%0d who=%0d slot=%0d",
							" total=%0d last=%0b, actual ev=%0d who=%0d slot=%0d",
							" total=%0d last=%0b"},
							$realtime, want.ev, want.who, want.slot, want.total, want.last,
							got.ev, got.who, got.slot, got.total, got.last);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) predict_events(s_axis_tuser, s_axis_tdata);
			pending <= event_q.size();
		end
	end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
	import lsa_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              s_axis_tvalid = 0;
	logic              s_axis_tready;
	logic [31:0]       s_axis_tdata = '0;   // requester, slot_index, amount, pad
	logic [OP_W-1:0]   s_axis_tuser = '0;   // op
	logic              m_axis_tvalid;
	logic              m_axis_tready = 0;
	logic [55:0]       m_axis_tdata;        // who, slot_number, running_total, pad
	logic [EV_W-1:0]   m_axis_tuser;        // event_res
	logic              m_axis_tlast;
	logic              cfg_we = 0;
	logic [CFG_W-1:0]  cfg_wdata = '0;
	int                fail_count, pending;

	// Idle odds in percent for the command and event sides.
	int                tx_idle = 11;
	int                rx_idle = 48;
	int                cycles = 0;

	// Requesters whose weight is loaded; only these may arrive, so no grant
	// ever reads an unwritten weight. All slot rates are loaded up front.
	bit                weight_set [REQ_COUNT];
	int                weighted_ids[$];
	int                arrived_ids[$];

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	lowest_slot_allocator_with_wait_queue_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	lsa_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending(pending)
	);

	// Stall the event side at random.
	always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= rx_idle);

	// Abort a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Present one command and hold it until the block takes it.
	task automatic send_cmd(input logic [OP_W-1:0] op, input int rid, input int sidx,
			input int amt);
		if ($urandom_range(99) < tx_idle) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {2'b00, 16'(amt), 6'(sidx), 8'(rid)};
		do @(posedge clk); while (!s_axis_tready);
		if (op == OP_LOAD_WEIGHT && !weight_set[rid]) begin
			weight_set[rid] = 1;
			weighted_ids.push_back(rid);
		end
		if (op == OP_ARRIVE) arrived_ids.push_back(rid);
		if (op == OP_CLEAR) arrived_ids.delete();
	endtask

	// Drop valid and let every outstanding event drain, plus the block's latency.
	task automatic wait_idle();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_slots(input int value);
		wait_idle();
		cfg_we    <= 1;
		cfg_wdata <= CFG_W'(value);
		@(posedge clk);
		cfg_we    <= 0;
	endtask

	task automatic random_cmd();
		int pick, rid;
		pick = $urandom_range(99);
		if (pick < 12) begin
			send_cmd(OP_LOAD_WEIGHT, $urandom_range(255), $urandom_range(63), $urandom);
		end else if (pick < 20) begin
			send_cmd(OP_LOAD_RATE, $urandom_range(255), $urandom_range(63), $urandom);
		end else if (pick < 58) begin
			rid = weighted_ids[$urandom_range(weighted_ids.size()-1)];
			send_cmd(OP_ARRIVE, rid, $urandom_range(63), $urandom);
		end else if (pick < 93) begin
			// Mostly depart someone who came in, sometimes a stranger.
			if (arrived_ids.size() > 0 && $urandom_range(9) < 8)
				rid = arrived_ids[$urandom_range(arrived_ids.size()-1)];
			else
				rid = $urandom_range(255);
			send_cmd(OP_DEPART, rid, $urandom_range(63), $urandom);
		end else if (pick < 96) begin
			send_cmd(OP_CLEAR, $urandom_range(255), $urandom_range(63), $urandom);
		end else begin
			send_cmd(OP_W'($urandom_range(7, 5)), $urandom_range(255), $urandom_range(63),
				$urandom);
		end
	endtask

	initial begin
		int slot_limits[5] = '{127, 3, 0, 100, 5};

		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Load every slot rate, extremes at the ends.
		for (int s = 0; s < SLOT_COUNT; s++)
			send_cmd(OP_LOAD_RATE, 0, s, (s == 0) ? 0 : (s == 63) ? 16'hFFFF : $urandom);

		// Directed: extreme ids and amounts, every op, error and repeat cases.
		send_cmd(OP_LOAD_WEIGHT, 255, 63, 16'hFFFF);
		send_cmd(OP_LOAD_WEIGHT, 0, 0, 0);
		send_cmd(OP_LOAD_WEIGHT, 170, 21, 16'hAAAA);
		send_cmd(OP_LOAD_WEIGHT, 85, 42, 16'h5555);
		send_cmd(OP_ARRIVE, 255, 0, 0);
		send_cmd(OP_ARRIVE, 0, 63, 16'hFFFF);
		send_cmd(OP_ARRIVE, 170, 0, 0);
		send_cmd(OP_DEPART, 0, 0, 0);
		send_cmd(OP_DEPART, 0, 0, 0);          // no longer holding
		send_cmd(OP_DEPART, 7, 0, 0);          // never arrived
		send_cmd(OP_ARRIVE, 255, 0, 0);        // already holding
		send_cmd(OP_ARRIVE, 85, 0, 0);
		send_cmd(OP_DEPART, 255, 0, 0);
		send_cmd(3'd5, 1, 1, 1);
		send_cmd(3'd6, 2, 2, 2);
		send_cmd(3'd7, 255, 63, 16'hFFFF);
		send_cmd(OP_CLEAR, 255, 63, 16'hFFFF);
		send_cmd(OP_DEPART, 85, 0, 0);         // hold dropped by clear

		for (int i = 0; i < 20; i++) random_cmd();

		// One usable slot: one requester at maximum weight and rate holds it and
		// fills the wait queue past its depth, then departs until the queue is
		// drained; the regrants drive the total into saturation.
		write_slots(1);
		tx_idle = 48;
		rx_idle = 11;
		send_cmd(OP_CLEAR, 0, 0, 0);
		send_cmd(OP_LOAD_RATE, 0, 0, 16'hFFFF);
		send_cmd(OP_LOAD_WEIGHT, 255, 0, 16'hFFFF);
		for (int i = 0; i < REQ_COUNT + 2; i++) send_cmd(OP_ARRIVE, 255, 0, 0);
		tx_idle = 0;
		rx_idle = 0;
		for (int i = 0; i < REQ_COUNT + 1; i++) send_cmd(OP_DEPART, 255, 0, 0);
		send_cmd(OP_CLEAR, 0, 0, 0);

		foreach (slot_limits[p]) begin
			write_slots(slot_limits[p]);
			for (int i = 0; i < 6; i++) begin
				random_cmd();
				if (p == 3 && i == 3) wait_idle();
			end
		end

		wait_idle();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/lsa_pkg.sv
rtl/core/lsa_ram.sv
rtl/core/lsa_prio.sv
rtl/core/lowest_slot_allocator_with_wait_queue_core.sv
verif/lsa_checker.sv
verif/tb.sv
